### hdl/mavg_pkg.sv
// Shared types and constants of the accelerometer moving-average and servo map block.
package mavg_pkg;

    // Field widths.
    localparam int ACC_W       = 16;
    localparam int CFG_W       = 12;
    localparam int ANGLE_W     = 8;
    localparam int PULSE_W     = 13;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 72;

    // Scaling constants: 16384 counts per g, 90 degrees per g, 180 degrees full travel.
    localparam int ONE_G_SHIFT   = 14;
    localparam int HALF_TURN_DEG = 90;
    localparam int FULL_TURN_DEG = 180;

    // Reciprocal of 180 for the pulse scaling: floor(p / 180) equals
    // (p * PULSE_RECIP) >> RECIP_SHIFT for every product of an angle and a 12-bit span.
    localparam int RECIP_W     = 21;
    localparam int RECIP_SHIFT = 28;
    localparam logic [RECIP_W-1:0] PULSE_RECIP = 21'd1491309;

    // Divider divisor width; holds the fill count.
    localparam int DIV_VW = 8;

    // Configuration register indexes and reset values.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_SPAN = 1'b1;
    localparam logic [CFG_W-1:0] PULSE_MIN_RST  = 12'd500;
    localparam logic [CFG_W-1:0] PULSE_SPAN_RST = 12'd2000;

    // One stored sample, x in the lowest bits.
    typedef struct packed {
        logic signed [ACC_W-1:0] z;
        logic signed [ACC_W-1:0] y;
        logic signed [ACC_W-1:0] x;
    } accel_sample_t;

    // Divider start request.
    typedef struct packed {
        logic              start;
        logic [DIV_VW-1:0] divisor;
    } div_ctl_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_PREP,
        ST_DIV_MEAN,
        ST_SCALE,
        ST_PULSE,
        ST_OUT
    } state_t;

endpackage

### hdl/accel_moving_average_servo_map.sv
// Top level of the three-axis moving-average filter with servo mapping of the x axis.
//
// Usage: one accelerometer sample (x, y, z raw counts) arrives per transfer on the
// s_axis channel; each sample yields exactly one result transfer on m_axis with the
// three windowed means, the servo angle and the servo pulse width. The pulse
// registers are written through cfg_wr_en / cfg_index / cfg_data; the user must
// write them only while idle, as the block itself does not enforce this.
// Timing: from its transfer to its result being registered, an item passes in order
// through the ring read, the sum update, the divider setup, the serial divider for
// the means and the angle, the pulse product, the scaling by 1/180 and the output
// load; a new sample is taken only once the sequencer is back in idle.
// One item is processed at a time; s_axis_tready is high only while the sequencer
// is idle, and a finished result may wait in the output register while the next
// sample is taken in.
// Reset clears the sums, the fill count, the write slot and the output valid, and
// restores the pulse registers to 500 and 2000 us. Ring entries are not cleared;
// the old value of an entry is used only after it has been written.
// If m_axis_tready stays low, the next result waits in the sequencer and no new
// sample is accepted until the output register frees up.
module accel_moving_average_servo_map #(
    parameter int WINDOW_DEPTH = 10
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Configuration write port.
    input  logic                                  cfg_wr_en,
    input  logic [mavg_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mavg_pkg::CFG_W-1:0]            cfg_data,
    // Sample input: tdata = accel_x[15:0], accel_y[31:16], accel_z[47:32].
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [mavg_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // Result output: tdata = mean_x[15:0], mean_y[31:16], mean_z[47:32],
    // servo_angle[55:48], servo_pulse_us[68:56], zeros[71:69].
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [mavg_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);
    import mavg_pkg::*;

    localparam int IDX_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = ACC_W + 1 + $clog2(WINDOW_DEPTH);
    localparam int PROD_W = CFG_W + ANGLE_W;
    localparam int RP_W   = PROD_W + RECIP_W;
    localparam int DIV_DW = SUM_W;
    localparam int SCL_W  = SUM_W + 7;
    localparam int LANES  = 4;

    state_t state_reg, state_next;

    logic [CFG_W-1:0]   pulse_min_reg, pulse_span_reg;
    logic [IDX_W-1:0]   slot_reg, slot_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic signed [SUM_W-1:0] sum_reg [3];
    logic signed [SUM_W-1:0] sum_next [3];
    accel_sample_t      sample_reg;
    accel_sample_t      ring_rdata;
    logic [ACC_W-1:0]   mean_reg [3];
    logic [ACC_W-1:0]   mean_next [3];
    logic [ANGLE_W-1:0] angle_reg;
    logic [PULSE_W-1:0] pulse_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic               out_valid_reg, out_valid_next;

    // Sequencer decode.
    logic ring_rd_en, ring_wr_en, mean_load, scale_load, pulse_load, out_load, accept;

    // Datapath signals.
    logic signed [SUM_W-1:0] new_ext [3];
    logic signed [SUM_W-1:0] old_ext [3];
    logic [SUM_W-1:0]        mag [3];
    logic signed [SUM_W-1:0] full_s, sx_cl;
    logic [SUM_W-1:0]        u_off;
    logic [SCL_W-1:0]        scaled;
    logic                    ring_full;
    logic [PROD_W-1:0]       prod;
    logic [RP_W-1:0]         recip_prod;
    logic [CFG_W-1:0]        span_part;

    div_ctl_t                     div_ctl;
    logic [LANES-1:0][DIV_DW-1:0] div_dvd;
    logic [LANES-1:0][DIV_DW-1:0] div_quo;
    logic                         div_done;

    mavg_ring #(
        .DEPTH (WINDOW_DEPTH),
        .AW    (IDX_W)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ring_wr_en),
        .wr_addr (slot_reg),
        .wr_data (sample_reg),
        .rd_en   (ring_rd_en),
        .rd_addr (slot_reg),
        .rd_data (ring_rdata)
    );

    mavg_div #(
        .LANES (LANES),
        .DW    (DIV_DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (div_dvd),
        .quotient (div_quo),
        .done     (div_done)
    );

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (s_axis_tvalid) state_next = ST_READ;
            ST_READ:      state_next = ST_UPDATE;
            ST_UPDATE:    state_next = ST_PREP;
            ST_PREP:      state_next = ST_DIV_MEAN;
            ST_DIV_MEAN:  if (div_done) state_next = ST_SCALE;
            ST_SCALE:     state_next = ST_PULSE;
            ST_PULSE:     state_next = ST_OUT;
            ST_OUT:       if (!out_valid_reg || m_axis_tready) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Output decode of the sequencer.
    always_comb
    begin
        s_axis_tready   = (state_reg == ST_IDLE);
        ring_rd_en      = (state_reg == ST_READ);
        ring_wr_en      = (state_reg == ST_UPDATE);
        mean_load       = (state_reg == ST_DIV_MEAN) && div_done;
        scale_load      = (state_reg == ST_SCALE);
        pulse_load      = (state_reg == ST_PULSE);
        out_load        = (state_reg == ST_OUT) && (!out_valid_reg || m_axis_tready);
        div_ctl.start   = (state_reg == ST_PREP);
        div_ctl.divisor = DIV_VW'(count_reg);
    end

    assign accept = s_axis_tvalid && s_axis_tready;

    // Sign-extended new and overwritten samples.
    always_comb
    begin
        new_ext[0] = {{(SUM_W-ACC_W){sample_reg.x[ACC_W-1]}}, sample_reg.x};
        new_ext[1] = {{(SUM_W-ACC_W){sample_reg.y[ACC_W-1]}}, sample_reg.y};
        new_ext[2] = {{(SUM_W-ACC_W){sample_reg.z[ACC_W-1]}}, sample_reg.z};
        old_ext[0] = {{(SUM_W-ACC_W){ring_rdata.x[ACC_W-1]}}, ring_rdata.x};
        old_ext[1] = {{(SUM_W-ACC_W){ring_rdata.y[ACC_W-1]}}, ring_rdata.y};
        old_ext[2] = {{(SUM_W-ACC_W){ring_rdata.z[ACC_W-1]}}, ring_rdata.z};
    end

    assign ring_full = (count_reg == CNT_W'(WINDOW_DEPTH));

    // Running sums, write slot and fill count, updated once per sample.
    always_comb
    begin
        slot_next  = slot_reg;
        count_next = count_reg;
        for (int a = 0; a < 3; a++)
        begin
            sum_next[a] = sum_reg[a];
        end
        if (ring_wr_en)
        begin
            for (int a = 0; a < 3; a++)
            begin
                sum_next[a] = sum_reg[a] + new_ext[a] - (ring_full ? old_ext[a] : '0);
            end
            slot_next = (slot_reg == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : slot_reg + 1'b1;
            if (!ring_full)
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    // Divider operands: magnitudes of the sums and the scaled, clamped x offset.
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            mag[a] = sum_reg[a][SUM_W-1] ? SUM_W'(-sum_reg[a]) : SUM_W'(sum_reg[a]);
        end
        full_s = SUM_W'(count_reg) << ONE_G_SHIFT;
        if (sum_reg[0] > full_s)
        begin
            sx_cl = full_s;
        end
        else if (sum_reg[0] < -full_s)
        begin
            sx_cl = -full_s;
        end
        else
        begin
            sx_cl = sum_reg[0];
        end
        u_off      = SUM_W'(sx_cl + full_s);
        scaled     = SCL_W'(u_off) * SCL_W'(HALF_TURN_DEG);
        div_dvd[0] = DIV_DW'(mag[0]);
        div_dvd[1] = DIV_DW'(mag[1]);
        div_dvd[2] = DIV_DW'(mag[2]);
        div_dvd[3] = DIV_DW'(scaled >> ONE_G_SHIFT);
    end

    // Pulse scaling: angle times span, then the quotient by 180 through its reciprocal.
    always_comb
    begin
        prod       = PROD_W'(angle_reg) * PROD_W'(pulse_span_reg);
        recip_prod = RP_W'(prod_reg) * RP_W'(PULSE_RECIP);
        span_part  = recip_prod[RECIP_SHIFT +: CFG_W];
    end

    // Means truncated toward zero: quotient of the magnitude with the sign of the sum.
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            mean_next[a] = sum_reg[a][SUM_W-1] ? ACC_W'(~div_quo[a][ACC_W-1:0] + 1'b1)
                                               : div_quo[a][ACC_W-1:0];
        end
    end

    // Output valid: set when a result loads, cleared when it is transferred.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            slot_reg       <= '0;
            count_reg      <= '0;
            sum_reg        <= '{default: '0};
            out_valid_reg  <= 1'b0;
            pulse_min_reg  <= PULSE_MIN_RST;
            pulse_span_reg <= PULSE_SPAN_RST;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_PULSE_MIN:  pulse_min_reg  <= cfg_data;
                    REG_PULSE_SPAN: pulse_span_reg <= cfg_data;
                    default:        ;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= accel_sample_t'(s_axis_tdata);
        end
        if (mean_load)
        begin
            mean_reg  <= mean_next;
            angle_reg <= div_quo[3][ANGLE_W-1:0];
        end
        if (scale_load)
        begin
            prod_reg <= prod;
        end
        if (pulse_load)
        begin
            pulse_reg <= PULSE_W'(pulse_min_reg) + PULSE_W'(span_part);
        end
        if (out_load)
        begin
            out_data_reg <= {3'b000, pulse_reg, angle_reg, mean_reg[2], mean_reg[1],
                             mean_reg[0]};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

### hdl/mavg_ring.sv
// Sample ring memory: one write port and one registered read port.
module mavg_ring #(
    parameter int DEPTH = 10,
    parameter int AW    = 4
) (
    input  logic                    clk,
    input  logic                    wr_en,
    input  logic [AW-1:0]           wr_addr,
    input  mavg_pkg::accel_sample_t wr_data,
    input  logic                    rd_en,
    input  logic [AW-1:0]           rd_addr,
    output mavg_pkg::accel_sample_t rd_data
);
    import mavg_pkg::*;

    accel_sample_t mem [DEPTH];
    accel_sample_t rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/mavg_div.sv
// Multi-lane restoring divider sharing one divisor, one quotient bit per cycle.
module mavg_div #(
    parameter int LANES = 4,
    parameter int DW    = 21
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  mavg_pkg::div_ctl_t        ctl,
    input  logic [LANES-1:0][DW-1:0]  dividend,
    output logic [LANES-1:0][DW-1:0]  quotient,
    output logic                      done
);
    import mavg_pkg::*;

    localparam int CNT_W = $clog2(DW + 1);

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [LANES-1:0][DW-1:0] dvd_reg, dvd_next;
    logic [DIV_VW-1:0]        rem_reg [LANES];
    logic [DIV_VW-1:0]        rem_next [LANES];
    logic [DIV_VW-1:0]        dsr_reg, dsr_next;
    logic [DIV_VW:0]          trial [LANES];

    // Shift-subtract step; after DW steps the dividend register holds the quotient.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        for (int l = 0; l < LANES; l++)
        begin
            rem_next[l] = rem_reg[l];
            trial[l]    = {rem_reg[l], dvd_reg[l][DW-1]};
        end
        if (ctl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DW);
            dvd_next  = dividend;
            dsr_next  = ctl.divisor;
            for (int l = 0; l < LANES; l++)
            begin
                rem_next[l] = '0;
            end
        end
        else if (busy_reg)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                if (trial[l] >= {1'b0, dsr_reg})
                begin
                    rem_next[l] = DIV_VW'(trial[l] - {1'b0, dsr_reg});
                    dvd_next[l] = {dvd_reg[l][DW-2:0], 1'b1};
                end
                else
                begin
                    rem_next[l] = trial[l][DIV_VW-1:0];
                    dvd_next[l] = {dvd_reg[l][DW-2:0], 1'b0};
                end
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign quotient = dvd_reg;
    assign done     = done_reg;

endmodule

### hdl/mavg_checker.sv
// Port-level checker for the moving-average servo map block, with its bind.
module mavg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // One sample at a time: a transfer closes the input for the next cycle.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a sample is in flight");

    // A new result appears only from the busy sequencer.
    a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared while idle");

    // An x mean at or above one g pins the angle at full travel.
    a_angle_top: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[15] && m_axis_tdata[14] |->
        m_axis_tdata[55:48] == 8'd180)
        else $error("angle not at full travel");

    // An x mean below minus one g pins the angle at zero.
    a_angle_bottom: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[15] && !m_axis_tdata[14] |->
        m_axis_tdata[55:48] == 8'd0)
        else $error("angle not at zero");

endmodule

bind accel_moving_average_servo_map mavg_checker u_mavg_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
